>>> rtl/core/zpfc_pkg.sv
// Shared constants, lookup tables and control types for the zoom position / fov converter.
package zpfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 31;
    localparam int TAB_CAP           = 31;
    localparam int CORDIC_STEPS      = 17;
    localparam int DIV_NUM_W         = 26;
    localparam int DIV_DEN_W         = 16;

    localparam logic [15:0] FOV_MAX_RESET = 16'd17971;
    localparam logic [15:0] FOV_LOW       = 16'd256;
    localparam logic [15:0] FOV_HIGH      = 16'd45824;
    localparam logic [15:0] RATIO_ONE     = 16'd256;
    localparam logic [15:0] RATIO_TOP     = 16'd61440;
    localparam logic [15:0] OPT_TOP       = 16'd5120;
    localparam logic [15:0] DIG_STEP      = 16'd5120;

    typedef struct packed {
        logic       load;       // capture request
        logic       decode;     // forward decode / reverse scan init
        logic       scan;       // test one reverse segment
        logic       mul;        // form dividend
        logic       div_start;  // launch divider
        logic       div_use;    // consume quotient
        logic       rot_init;   // load CORDIC rotation start vector
        logic       step;       // one CORDIC iteration
        logic       vec;        // iteration is vectoring mode
        logic       scale;      // apply ratio between the two passes
        logic       fov_fin;    // round and clamp angle into fov
        logic [4:0] k;          // CORDIC iteration index
    } zpfc_cmd_t;

    typedef struct packed {
        logic is_rev;
        logic fwd_ok;
        logic fwd_top;
        logic hit;
        logic last_seg;
        logic div_done;
    } zpfc_sts_t;

    function automatic logic [15:0] lens_tab(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:  v = 16'h0000;  5'd1:  v = 16'h0DC1;  5'd2:  v = 16'h186C;
            5'd3:  v = 16'h2015;  5'd4:  v = 16'h2594;  5'd5:  v = 16'h29B7;
            5'd6:  v = 16'h2CFB;  5'd7:  v = 16'h2FB0;  5'd8:  v = 16'h320C;
            5'd9:  v = 16'h342D;  5'd10: v = 16'h3608;  5'd11: v = 16'h37AA;
            5'd12: v = 16'h391C;  5'd13: v = 16'h3A66;  5'd14: v = 16'h3B90;
            5'd15: v = 16'h3C9C;  5'd16: v = 16'h3D91;  5'd17: v = 16'h3E72;
            5'd18: v = 16'h3F40;  5'd19: v = 16'h4000;  5'd20: v = 16'h6000;
            5'd21: v = 16'h6AAB;  5'd22: v = 16'h7000;  5'd23: v = 16'h7334;
            5'd24: v = 16'h7556;  5'd25: v = 16'h76DC;  5'd26: v = 16'h7800;
            5'd27: v = 16'h78E4;  5'd28: v = 16'h799A;  5'd29: v = 16'h7A2F;
            5'd30: v = 16'h7AC0;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // atan(2^-k) in degrees, Q16.16
    function automatic logic [22:0] atan_tab(input logic [4:0] k);
        logic [22:0] v;
        unique case (k)
            5'd0:  v = 23'd2949120; 5'd1:  v = 23'd1740967; 5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;  5'd4:  v = 23'd234378;  5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;   5'd7:  v = 23'd29335;   5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;    5'd10: v = 23'd3667;    5'd11: v = 23'd1833;
            5'd12: v = 23'd917;     5'd13: v = 23'd458;     5'd14: v = 23'd229;
            5'd15: v = 23'd115;     5'd16: v = 23'd57;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // zoom multiple at table entry
    function automatic logic [7:0] step_ratio(input logic [4:0] i);
        logic [7:0] v;
        if (i < 5'd20) begin
            v = 8'({3'b0, i} + 8'd1);
        end else begin
            v = 8'(({3'b0, i} - 8'd18) * 8'd20);
        end
        return v;
    endfunction

endpackage

>>> rtl/core/zpfc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module zpfc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [zpfc_pkg::DIV_NUM_W-1:0]  numer,
    input  logic [zpfc_pkg::DIV_DEN_W-1:0]  denom,
    output logic [zpfc_pkg::DIV_NUM_W-1:0]  quot,
    output logic                            done
);
    import zpfc_pkg::*;

    localparam int CntW = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = numer;
            rem_next = '0;
            den_next = denom;
            cnt_next = CntW'(DIV_NUM_W);
        end else if (cnt_reg != '0) begin
            if (!trial[DIV_DEN_W]) begin
                rem_next = trial[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CntW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;
endmodule

>>> rtl/core/zpfc_datapath.sv
// Datapath: request capture, table interpolation, shared divider and CORDIC fov unit.
module zpfc_datapath #(
    parameter int TABLE_ENTRIES = zpfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  zpfc_pkg::zpfc_cmd_t cmd,
    output zpfc_pkg::zpfc_sts_t sts,
    input  logic                req_type,
    input  logic [15:0]         zoom_ratio_in,
    input  logic [15:0]         lens_position_in,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output logic                valid_res,
    output logic [14:0]         lens_position_out,
    output logic [15:0]         zoom_ratio_out,
    output logic [15:0]         fov_out
);
    import zpfc_pkg::*;

    localparam int UsedLen = (TABLE_ENTRIES > TAB_CAP) ? TAB_CAP :
                             ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam logic [4:0] LastEntry = 5'(UsedLen - 1);
    localparam logic [4:0] LastSeg   = 5'(UsedLen - 2);
    localparam logic [15:0] LastPos  = lens_tab(LastEntry);

    logic               rtype_reg;
    logic [15:0]        rin_reg, pin_reg;
    logic [15:0]        fov_max_reg, ratio_reg, fov_reg;
    logic               res_valid_reg;
    logic [14:0]        pos_reg;
    logic [4:0]         seg_reg;
    logic [13:0]        num_reg;
    logic [15:0]        den_reg;
    logic [25:0]        prod_reg;
    logic signed [47:0] x_reg, y_reg;
    logic signed [24:0] z_reg;

    // forward decode
    logic [3:0]  q;
    logic [4:0]  f_seg;
    logic [13:0] f_num;
    logic [15:0] f_den;
    logic        f_ok, f_top;

    always_comb begin
        q = '0;
        for (int j = 1; j <= 12; j++) begin
            if (rin_reg >= 16'(j * 5120)) q = q + 1'b1;
        end
        f_ok = (rin_reg >= RATIO_ONE) && (rin_reg <= RATIO_TOP);
        if (rin_reg <= OPT_TOP) begin
            f_seg = rin_reg[12:8] - 5'd1;
            f_num = {6'b0, rin_reg[7:0]};
            f_den = 16'd256;
        end else begin
            f_seg = {1'b0, q} + 5'd18;
            f_num = 14'(rin_reg - 16'({12'b0, q} * DIG_STEP));
            f_den = DIG_STEP;
        end
        f_top = ({1'b0, f_seg} + 6'd1) >= 6'(UsedLen);
    end

    // segment under test / in use
    logic [15:0] t_lo, t_hi, span;
    logic [4:0]  dm;
    logic        hit;
    logic [17:0] rev_num;

    assign t_lo    = lens_tab(seg_reg);
    assign t_hi    = lens_tab(seg_reg + 5'd1);
    assign span    = t_hi - t_lo;
    assign dm      = (seg_reg < 5'd19) ? 5'd1 : 5'd20;
    assign hit     = (pin_reg >= t_lo) && (pin_reg <= t_hi);
    assign rev_num = 18'(num_reg) * 18'(dm);

    // divider
    logic [DIV_NUM_W-1:0] quot;
    logic                 div_done;

    zpfc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (prod_reg),
        .denom   (den_reg),
        .quot    (quot),
        .done    (div_done)
    );

    // CORDIC
    logic [15:0]        fmc;
    logic signed [47:0] xs, ys;
    logic signed [24:0] ang;
    logic               sigma;
    logic signed [29:0] x30;
    logic signed [16:0] r17;
    logic signed [46:0] xprod;
    logic signed [24:0] zc, zr;

    assign fmc   = (fov_max_reg < FOV_LOW) ? FOV_LOW :
                   ((fov_max_reg > FOV_HIGH) ? FOV_HIGH : fov_max_reg);
    assign xs    = x_reg >>> cmd.k;
    assign ys    = y_reg >>> cmd.k;
    assign ang   = signed'({2'b0, atan_tab(cmd.k)});
    assign sigma = cmd.vec ? !(y_reg > 48'sd0) : !z_reg[24];
    assign x30   = x_reg[29:0];
    assign r17   = signed'({1'b0, ratio_reg});
    assign xprod = x30 * r17;
    assign zc    = z_reg[24] ? 25'sd0 : z_reg;
    assign zr    = (zc + 25'sd64) >>> 7;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rtype_reg <= req_type;
            rin_reg   <= zoom_ratio_in;
            pin_reg   <= lens_position_in;
        end
        if (cmd.decode) begin
            res_valid_reg <= !rtype_reg && f_ok;
            pos_reg       <= (!rtype_reg && f_ok && f_top) ? LastPos[14:0] : '0;
            seg_reg       <= rtype_reg ? 5'd0 : f_seg;
            num_reg       <= f_num;
            den_reg       <= f_den;
        end
        if (cmd.scan) begin
            if (hit) begin
                num_reg <= 14'(pin_reg - t_lo);
                den_reg <= span;
            end else begin
                seg_reg <= seg_reg + 5'd1;
            end
        end
        if (cmd.mul) begin
            if (rtype_reg) prod_reg <= {rev_num, 8'b0};
            else           prod_reg <= 26'(num_reg * span[13:0]);
        end
        if (cmd.div_use && !rtype_reg) begin
            pos_reg <= 15'(t_lo + quot[15:0]);
        end
        if (cmd.rot_init) begin
            x_reg <= 48'sd1 <<< 28;
            y_reg <= '0;
            z_reg <= signed'({2'b0, fmc, 7'b0});
        end
        if (cmd.step) begin
            if (sigma) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
        if (cmd.scale) begin
            x_reg <= 48'(xprod);
            y_reg <= y_reg <<< 8;
            z_reg <= '0;
        end
    end

    // held state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fov_max_reg <= FOV_MAX_RESET;
            ratio_reg   <= RATIO_ONE;
            fov_reg     <= FOV_MAX_RESET;
        end else begin
            if (cfg_wr_en) fov_max_reg <= cfg_wr_data;
            if (cmd.div_use && rtype_reg) begin
                ratio_reg     <= {step_ratio(seg_reg), 8'b0} + quot[15:0];
            end
            if (cmd.fov_fin) begin
                fov_reg <= (zr > 25'sd45824) ? FOV_HIGH : zr[15:0];
            end
        end
    end

    // reverse hit marks the result valid once the new ratio lands
    logic rev_valid_reg;
    always_ff @(posedge aclk) begin
        if (cmd.decode) rev_valid_reg <= 1'b0;
        if (cmd.div_use && rtype_reg) rev_valid_reg <= 1'b1;
    end

    assign sts.is_rev   = rtype_reg;
    assign sts.fwd_ok   = f_ok;
    assign sts.fwd_top  = f_top;
    assign sts.hit      = hit;
    assign sts.last_seg = (seg_reg == LastSeg);
    assign sts.div_done = div_done;

    assign valid_res         = rtype_reg ? rev_valid_reg : res_valid_reg;
    assign lens_position_out = pos_reg;
    assign zoom_ratio_out    = ratio_reg;
    assign fov_out           = fov_reg;
endmodule

>>> rtl/core/zpfc_ctrl.sv
// Controller state machine sequencing decode, scan, divide and CORDIC passes.
module zpfc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    output logic                out_load,
    output zpfc_pkg::zpfc_cmd_t cmd,
    input  zpfc_pkg::zpfc_sts_t sts
);
    import zpfc_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_SCAN    = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_DIVGO   = 4'd4;
    localparam logic [3:0] ST_DIVWAIT = 4'd5;
    localparam logic [3:0] ST_ROTINIT = 4'd6;
    localparam logic [3:0] ST_ROT     = 4'd7;
    localparam logic [3:0] ST_SCALE   = 4'd8;
    localparam logic [3:0] ST_VEC     = 4'd9;
    localparam logic [3:0] ST_FOVFIN  = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.k      = cnt_reg;
        out_load   = 1'b0;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                if (sts.is_rev)                       state_next = ST_SCAN;
                else if (sts.fwd_ok && !sts.fwd_top)  state_next = ST_MUL;
                else                                  state_next = ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit)           state_next = ST_MUL;
                else if (sts.last_seg) state_next = ST_DONE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (sts.div_done) begin
                    cmd.div_use = 1'b1;
                    state_next  = sts.is_rev ? ST_ROTINIT : ST_DONE;
                end
            end
            ST_ROTINIT: begin
                cmd.rot_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_ROT;
            end
            ST_ROT: begin
                cmd.step = 1'b1;
                if (cnt_reg == LastStep) begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_VEC;
            end
            ST_VEC: begin
                cmd.step = 1'b1;
                cmd.vec  = 1'b1;
                if (cnt_reg == LastStep) begin
                    cnt_next   = '0;
                    state_next = ST_FOVFIN;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_FOVFIN: begin
                cmd.fov_fin = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

>>> rtl/core/zoom_position_fov_converter.sv
// Top level: zoom ratio <-> lens position converter with fov tracking.
//
// Input channel (s_*): one transaction per request. s_tuser selects the
// direction: 0 = ratio to lens position, 1 = reported lens position to
// ratio and fov. Output channel (m_*): exactly one result transaction per
// request, in request order.
// Config: cfg_wr_en / cfg_wr_data write fov_max (Q8.8 degrees); write only
// while no request is in flight.
// Steps per request, input accept to result valid:
//   forward, out of range or top entry: decode only
//   forward, interpolated: decode, multiply, shared divider
//   reverse, no segment hit: decode, scan of segments (up to TABLE_ENTRIES-1)
//   reverse, hit: decode, segment scan, multiply, divider, 2 x 17 CORDIC steps
// Throughput is one request at a time; the next request is taken once the
// result is parked in the output register, so a stalled receiver holds at
// most one result plus one request in flight.
// Reset (aresetn low, synchronous): fov_max = 70.2 deg, held ratio = 1.0,
// held fov = 70.2 deg, both channels empty.
module zoom_position_fov_converter #(
    parameter int TABLE_ENTRIES = zpfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] zoom_ratio_in, [31:16] lens_position_in
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [14:0] lens_position_out, [30:15] zoom_ratio_out,
                                   // [46:31] fov_out, [47] zero
    output logic [0:0]  m_tuser,   // [0] valid_res
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import zpfc_pkg::*;

    zpfc_cmd_t   cmd;
    zpfc_sts_t   sts;
    logic        out_free, out_load;
    logic        valid_res;
    logic [14:0] lens_position_out;
    logic [15:0] zoom_ratio_out, fov_out;

    // output register: frees the datapath while the receiver stalls
    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg;
    logic [0:0]  m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    zpfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .sts      (sts)
    );

    zpfc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .req_type          (s_tuser[0]),
        .zoom_ratio_in     (s_tdata[15:0]),
        .lens_position_in  (s_tdata[31:16]),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .valid_res         (valid_res),
        .lens_position_out (lens_position_out),
        .zoom_ratio_out    (zoom_ratio_out),
        .fov_out           (fov_out)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)      m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= {1'b0, fov_out, zoom_ratio_out, lens_position_out};
            m_tuser_reg <= valid_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
